// File: src/mfps_pkg.sv
// Shared types and constants for the maximum falling path sum unit.
// No dependencies; every other file in src imports this package.
`default_nettype none
package mfps_pkg;

    localparam int unsigned COUNT_W      = 11;
    localparam int unsigned CELL_W       = 16;
    localparam int unsigned SUM_W        = 32;
    localparam int unsigned MAX_COLS_DEF = 1024;
    localparam int unsigned QUEUE_DEPTH  = 2;

    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1024);
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};

    typedef struct packed {
        logic signed [CELL_W-1:0] cell_value;
        logic                     last_cell;
    } t_in_item;

    typedef struct packed {
        logic signed [SUM_W-1:0] max_sum;
        logic                    row_incomplete;
    } t_out_item;

    typedef struct packed {
        logic signed [CELL_W-1:0] cell_value;
        logic                     last_cell;
        logic                     first_row;
        logic                     row_end;
        logic                     has_left;
        logic                     has_right;
    } t_cmd;

endpackage
`default_nettype wire

// File: src/mfps_front.sv
// Front end: holds the column count register, accepts input words and
// classifies each cell by position in the row. Depends on mfps_pkg.
`default_nettype none
module mfps_front #(
    parameter int unsigned MAX_COLS = mfps_pkg::MAX_COLS_DEF,
    parameter int unsigned IDX_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_valid,
    input  wire  [mfps_pkg::COUNT_W-1:0]     i_cfg_data,
    input  wire                              i_in_valid,
    input  wire  mfps_pkg::t_in_item         i_in_data,
    input  wire                              i_q_full,
    output logic                             o_in_stall,
    output logic                             o_push,
    output mfps_pkg::t_cmd                   o_cmd,
    output logic [IDX_W-1:0]                 o_idx
);
    import mfps_pkg::*;

    localparam int unsigned CMP_W = (IDX_W + 1 > COUNT_W) ? IDX_W + 1 : COUNT_W;
    localparam logic [CMP_W-1:0] MAX_C = CMP_W'(MAX_COLS);

    logic [COUNT_W-1:0] r_column_count;
    logic [IDX_W-1:0]   r_col_idx;
    logic               r_first_row;
    logic [IDX_W-1:0]   n_col_idx;
    logic               n_first_row;
    logic [CMP_W-1:0]   cnt_ext;
    logic [CMP_W-1:0]   eff_cnt;
    logic [CMP_W-1:0]   j_next;
    logic               row_end;

    always_comb begin
        cnt_ext = CMP_W'(r_column_count);
        if (cnt_ext == '0) begin
            eff_cnt = CMP_W'(1);
        end else if (cnt_ext > MAX_C) begin
            eff_cnt = MAX_C;
        end else begin
            eff_cnt = cnt_ext;
        end
        j_next  = CMP_W'(r_col_idx) + CMP_W'(1);
        row_end = (j_next >= eff_cnt);
    end

    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;
    assign o_idx      = r_col_idx;

    always_comb begin
        o_cmd.cell_value = i_in_data.cell_value;
        o_cmd.last_cell  = i_in_data.last_cell;
        o_cmd.first_row  = r_first_row;
        o_cmd.row_end    = row_end;
        o_cmd.has_left   = (r_col_idx != '0);
        o_cmd.has_right  = (j_next < eff_cnt);
    end

    always_comb begin
        n_col_idx   = r_col_idx;
        n_first_row = r_first_row;
        if (o_push) begin
            priority if (i_in_data.last_cell) begin
                n_col_idx   = '0;
                n_first_row = 1'b1;
            end else if (row_end) begin
                n_col_idx   = '0;
                n_first_row = 1'b0;
            end else begin
                n_col_idx   = IDX_W'(j_next);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column_count <= COUNT_RESET;
            r_col_idx      <= '0;
            r_first_row    <= 1'b1;
        end else begin
            if (i_cfg_valid) begin
                r_column_count <= i_cfg_data;
            end
            r_col_idx   <= n_col_idx;
            r_first_row <= n_first_row;
        end
    end

endmodule
`default_nettype wire

// File: src/mfps_queue.sv
// Short FIFO between front and back end of the path sum unit.
// Depends on mfps_pkg for its depth.
`default_nettype none
module mfps_queue #(
    parameter int unsigned DATA_W = 8
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  wire  [DATA_W-1:0]   i_data,
    input  wire                 i_pop,
    output logic                o_valid,
    output logic                o_full,
    output logic [DATA_W-1:0]   o_data
);
    import mfps_pkg::*;

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

    logic [DATA_W-1:0] r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              do_pop;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_data  = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            unique case ({i_push, do_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

// File: src/mfps_back.sv
// Back end: row store, path sum update with saturation, row maximum and
// the output word register. Depends on mfps_pkg.
`default_nettype none
module mfps_back #(
    parameter int unsigned MAX_COLS = mfps_pkg::MAX_COLS_DEF,
    parameter int unsigned IDX_W    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_cmd_valid,
    input  wire  mfps_pkg::t_cmd      i_cmd,
    input  wire  [IDX_W-1:0]          i_idx,
    output logic                      o_cmd_pop,
    input  wire                       i_out_stall,
    output logic                      o_out_valid,
    output mfps_pkg::t_out_item       o_out_data
);
    import mfps_pkg::*;

    logic signed [SUM_W-1:0] r_row [MAX_COLS];

    logic                    r_s1_valid;
    t_cmd                    r_s1_cmd;
    logic [IDX_W-1:0]        r_s1_idx;
    logic signed [SUM_W-1:0] r_here;
    logic signed [SUM_W-1:0] r_right;
    logic signed [SUM_W-1:0] r_left;
    logic signed [SUM_W-1:0] r_row_best;
    logic                    r_out_valid;
    t_out_item               r_out_data;

    logic                    adv;
    logic                    fire;
    logic [IDX_W-1:0]        rd_right_addr;
    logic signed [SUM_W-1:0] best;
    logic signed [SUM_W:0]   wide;
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] best_out;

    assign adv           = !(r_out_valid && i_out_stall);
    assign fire          = adv && r_s1_valid;
    assign o_cmd_pop     = adv && i_cmd_valid;
    assign rd_right_addr = i_idx + IDX_W'(1);

    always_comb begin
        best = r_here;
        if (r_s1_cmd.has_left && (r_left > best)) begin
            best = r_left;
        end
        if (r_s1_cmd.has_right && (r_right > best)) begin
            best = r_right;
        end
        if (r_s1_cmd.first_row) begin
            wide = (SUM_W + 1)'(r_s1_cmd.cell_value);
        end else begin
            wide = (SUM_W + 1)'(r_s1_cmd.cell_value) + (SUM_W + 1)'(best);
        end
        if (wide[SUM_W] != wide[SUM_W-1]) begin
            sum = wide[SUM_W] ? SUM_MIN : SUM_MAX;
        end else begin
            sum = wide[SUM_W-1:0];
        end
        best_out = (sum > r_row_best) ? sum : r_row_best;
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_row[r_s1_idx] <= sum;
        end
    end

    // read one column ahead; forward the sum being written this cycle
    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_s1_cmd <= i_cmd;
            r_s1_idx <= i_idx;
            r_here   <= (fire && (r_s1_idx == i_idx)) ? sum : r_row[i_idx];
            r_right  <= (fire && (r_s1_idx == rd_right_addr)) ? sum : r_row[rd_right_addr];
        end
        if (fire) begin
            r_left <= r_here;
        end
        if (fire && r_s1_cmd.last_cell) begin
            r_out_data.max_sum        <= best_out;
            r_out_data.row_incomplete <= !r_s1_cmd.row_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_row_best  <= SUM_MIN;
            r_out_valid <= 1'b0;
        end else begin
            if (adv) begin
                r_s1_valid <= i_cmd_valid;
            end
            if (fire) begin
                if (r_s1_cmd.last_cell || r_s1_cmd.row_end) begin
                    r_row_best <= SUM_MIN;
                end else begin
                    r_row_best <= best_out;
                end
            end
            if (fire && r_s1_cmd.last_cell) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
`default_nettype wire

// File: src/max_falling_path_sum_unit.sv
// Top level of the maximum falling path sum unit: front end, queue, back end.
// Depends on mfps_pkg, mfps_front, mfps_queue and mfps_back.
//
//   channel   direction  handshake           word
//   in        input      i_in_valid/o_in_stall   t_in_item (cell, last flag)
//   out       output     o_out_valid/i_out_stall t_out_item (max sum, partial row)
//   cfg       input      i_cfg_valid/o_cfg_ready column count, 11 bits
//
// One cell per cycle sustained while the output is not stalled; after its last
// cell is taken, a result word follows queue write, row store read, then update.
// The row store has one write and two registered reads per cycle.
// Synchronous active-low reset; the row store is not cleared.
// A stalled output word holds the back end; the two-entry queue then fills
// and stalls the input.
`default_nettype none
module max_falling_path_sum_unit #(
    parameter int unsigned MAX_COLS = mfps_pkg::MAX_COLS_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire  [mfps_pkg::COUNT_W-1:0]      i_cfg_data,
    input  wire                               i_in_valid,
    output logic                              o_in_stall,
    input  wire  mfps_pkg::t_in_item          i_in_data,
    output logic                              o_out_valid,
    input  wire                               i_out_stall,
    output mfps_pkg::t_out_item               o_out_data
);
    import mfps_pkg::*;

    localparam int unsigned IDX_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int unsigned Q_W   = $bits(t_cmd) + IDX_W;

    logic             push;
    logic             q_full;
    logic             q_valid;
    logic             q_pop;
    t_cmd             f_cmd;
    logic [IDX_W-1:0] f_idx;
    logic [Q_W-1:0]   q_out;
    t_cmd             b_cmd;
    logic [IDX_W-1:0] b_idx;

    assign o_cfg_ready = 1'b1;

    mfps_front #(
        .MAX_COLS (MAX_COLS),
        .IDX_W    (IDX_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .i_q_full    (q_full),
        .o_in_stall  (o_in_stall),
        .o_push      (push),
        .o_cmd       (f_cmd),
        .o_idx       (f_idx)
    );

    mfps_queue #(
        .DATA_W (Q_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_idx, f_cmd}),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_data  (q_out)
    );

    assign b_cmd = q_out[$bits(t_cmd)-1:0];
    assign b_idx = q_out[Q_W-1:$bits(t_cmd)];

    mfps_back #(
        .MAX_COLS (MAX_COLS),
        .IDX_W    (IDX_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (b_cmd),
        .i_idx       (b_idx),
        .o_cmd_pop   (q_pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire
